// ===== hdl/scsa_pkg.sv =====
// shared types, constants and helpers for the size-class slab allocator
// no dependencies; imported by all other files of the project
`default_nettype none

package scsa_pkg;

  localparam int unsigned NUM_PAGES_DEF = 64;
  localparam int unsigned NUM_CLASSES   = 7;
  localparam int unsigned PAGE_BYTES    = 4096;
  localparam int unsigned ADDR_W        = 18;
  localparam int unsigned OFF_W         = 12;
  localparam int unsigned SIZE_W        = 16;
  localparam int unsigned SLOT_W        = 7;
  localparam int unsigned SLOT_ROW      = PAGE_BYTES / 32;
  localparam int unsigned CLS_W         = 3;
  localparam int unsigned THR_W         = 4;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned RPAGE_W       = 6;
  localparam int unsigned MIN_SHIFT     = 5;
  localparam int unsigned MAX_REQ       = 2048;
  localparam int unsigned THR_RESET     = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_PAGE  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_DEC,
    S_A_SCAN,
    S_A_FILL,
    S_A_WALK_RD,
    S_A_WALK,
    S_A_GRANT,
    S_F_RD,
    S_F_CHK,
    S_F_DUP,
    S_F_COMMIT,
    S_F_REL_RD,
    S_F_REL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_inc;
    logic    init_page;
    logic    fill_inc;
    logic    walk_start;
    logic    walk_step;
    logic    pop;
    logic    frd;
    logic    f_latch;
    logic    dup_step;
    logic    commit;
    logic    rel_start;
    logic    rel_step;
    logic    release_pg;
    logic    finish;
    logic    grant;
    status_e status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_size;
    logic cfo_zero;
    logic scan_hit;
    logic scan_last;
    logic fill_last;
    logic cur_null;
    logic walk_hit;
    logic walk_stop;
    logic f_bad_pre;
    logic f_bad_chk;
    logic dup_match;
    logic dup_done;
    logic over_thr;
    logic rel_hit;
    logic rel_stop;
  } dp_stat_t;

  // objects per page minus the reserved slot 0
  function automatic logic [SLOT_W-1:0] cap_m1(input logic [CLS_W-1:0] c);
    logic [SLOT_W:0] cap;
    cap = (SLOT_W+1)'(SLOT_ROW) >> c;
    return SLOT_W'(cap - (SLOT_W+1)'(1));
  endfunction

  // low offset bits that must be clear for an aligned object
  function automatic logic [OFF_W-1:0] obj_mask(input logic [CLS_W-1:0] c);
    logic [OFF_W-1:0] m;
    m = ~({OFF_W{1'b1}} << (MIN_SHIFT + c));
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/scsa_ctrl.sv =====
// controller state machine of the slab allocator
// uses scsa_pkg; drives scsa_dp through ctrl_cmd_t and reads dp_stat_t
`default_nettype none

module scsa_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire logic                 cmd_i,
  input  wire scsa_pkg::dp_stat_t   stat_i,
  output logic                      busy,
  output logic                      done_o,
  output scsa_pkg::ctrl_cmd_t       cmd_o
);
  import scsa_pkg::*;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = (cmd_e'(cmd_i) == CMD_FREE) ? S_F_RD : S_A_DEC;
      end
      S_A_DEC: begin
        if (stat_i.bad_size) state_d = S_IDLE;
        else if (stat_i.cfo_zero) state_d = S_A_SCAN;
        else state_d = S_A_WALK_RD;
      end
      S_A_SCAN: begin
        if (stat_i.scan_hit) state_d = S_A_FILL;
        else if (stat_i.scan_last) state_d = S_IDLE;
      end
      S_A_FILL: begin
        if (stat_i.fill_last) state_d = S_A_WALK_RD;
      end
      S_A_WALK_RD: begin
        state_d = stat_i.cur_null ? S_IDLE : S_A_WALK;
      end
      S_A_WALK: begin
        if (stat_i.walk_hit) state_d = S_A_GRANT;
        else if (stat_i.walk_stop) state_d = S_IDLE;
      end
      S_A_GRANT: state_d = S_IDLE;
      S_F_RD: begin
        state_d = stat_i.f_bad_pre ? S_IDLE : S_F_CHK;
      end
      S_F_CHK: begin
        state_d = stat_i.f_bad_chk ? S_IDLE : S_F_DUP;
      end
      S_F_DUP: begin
        if (stat_i.dup_match) state_d = S_IDLE;
        else if (stat_i.dup_done) state_d = S_F_COMMIT;
      end
      S_F_COMMIT: begin
        state_d = stat_i.over_thr ? S_F_REL_RD : S_IDLE;
      end
      S_F_REL_RD: begin
        state_d = stat_i.cur_null ? S_IDLE : S_F_REL;
      end
      S_F_REL: begin
        if (stat_i.rel_hit || stat_i.rel_stop) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_A_DEC: begin
        if (stat_i.bad_size) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_BAD_SIZE;
        end else if (!stat_i.cfo_zero) begin
          cmd_o.walk_start = 1'b1;
        end
      end
      S_A_SCAN: begin
        if (stat_i.scan_hit) begin
          cmd_o.init_page = 1'b1;
        end else if (stat_i.scan_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NO_PAGE;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_A_FILL: begin
        cmd_o.fill_inc   = 1'b1;
        cmd_o.walk_start = stat_i.fill_last;
      end
      S_A_WALK_RD: begin
        if (stat_i.cur_null) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NO_PAGE;
        end
      end
      S_A_WALK: begin
        if (stat_i.walk_hit) begin
          cmd_o.pop = 1'b1;
        end else if (stat_i.walk_stop) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NO_PAGE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_A_GRANT: begin
        cmd_o.finish = 1'b1;
        cmd_o.grant  = 1'b1;
      end
      S_F_RD: begin
        cmd_o.frd = 1'b1;
        if (stat_i.f_bad_pre) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_BAD_FREE;
        end
      end
      S_F_CHK: begin
        cmd_o.f_latch = 1'b1;
        if (stat_i.f_bad_chk) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_BAD_FREE;
        end
      end
      S_F_DUP: begin
        if (stat_i.dup_match) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_BAD_FREE;
        end else if (!stat_i.dup_done) begin
          cmd_o.dup_step = 1'b1;
        end
      end
      S_F_COMMIT: begin
        cmd_o.commit    = 1'b1;
        cmd_o.rel_start = stat_i.over_thr;
        cmd_o.finish    = !stat_i.over_thr;
      end
      S_F_REL_RD: begin
        cmd_o.finish = stat_i.cur_null;
      end
      S_F_REL: begin
        if (stat_i.rel_hit) begin
          cmd_o.release_pg = 1'b1;
          cmd_o.finish     = 1'b1;
        end else if (stat_i.rel_stop) begin
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.rel_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign done_d = cmd_o.finish;
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_done_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_q) else $error("went idle without a result");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

// ===== hdl/scsa_dp.sv =====
// datapath of the slab allocator: page tables, slot stacks, class counters
// uses scsa_pkg; commanded by scsa_ctrl
`default_nettype none

module scsa_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [scsa_pkg::THR_W-1:0]       cfg_data_i,
  input  wire logic                             cmd_i,
  input  wire logic [scsa_pkg::SIZE_W-1:0]      request_size_i,
  input  wire logic [scsa_pkg::ADDR_W-1:0]      object_address_i,
  input  wire scsa_pkg::ctrl_cmd_t              cmd_in_i,
  output scsa_pkg::dp_stat_t                    stat_o,
  output logic [scsa_pkg::ADDR_W-1:0]           granted_address_o,
  output logic [scsa_pkg::STATUS_W-1:0]         status_o,
  output logic                                  released_valid_o,
  output logic [scsa_pkg::RPAGE_W-1:0]          released_page_o
);
  import scsa_pkg::*;

  localparam int unsigned NUM_PAGES = NUM_PAGES_DEF;
  localparam int unsigned PW    = $clog2(NUM_PAGES);
  localparam int unsigned LW    = $clog2(NUM_PAGES + 1);
  localparam int unsigned SA_W  = PW + SLOT_W;
  localparam int unsigned CFO_W = $clog2(NUM_PAGES * (SLOT_ROW - 1) + 1);
  localparam logic [LW-1:0] LINK_NULL = LW'(NUM_PAGES);
  localparam logic [PW-1:0] LAST_PG   = PW'(NUM_PAGES - 1);

  // item registers
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;

  // walk and sequencing registers
  logic [PW-1:0]     scan_q;
  logic [SLOT_W-1:0] fill_q;
  logic [LW-1:0]     cur_q, prev_q;
  logic [PW-1:0]     steps_q;
  logic [THR_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] fs_q, slot_q, dup_cnt_q;
  logic [CLS_W-1:0]  fcls_q;
  logic              is_free_q, chk_v_q;

  // allocator state
  logic [NUM_PAGES-1:0] in_use_q;
  logic [LW-1:0]        head_q  [NUM_CLASSES];
  logic [CFO_W-1:0]     cfo_q   [NUM_CLASSES];
  logic [LW-1:0]        whole_q [NUM_CLASSES];
  logic [THR_W-1:0]     thr_q;

  // memories
  logic [SLOT_W-1:0] pg_fs_mem   [NUM_PAGES];
  logic [LW-1:0]     pg_link_mem [NUM_PAGES];
  logic [CLS_W-1:0]  pg_cls_mem  [NUM_PAGES];
  logic [SLOT_W-1:0] stk_mem     [NUM_PAGES * SLOT_ROW];

  logic [SLOT_W-1:0] fs_rd_q, stk_rd_q;
  logic [LW-1:0]     link_rd_q;
  logic [CLS_W-1:0]  cls_rd_q;

  logic [PW-1:0]     pg_raddr;
  logic              fs_we, link_we, cls_we;
  logic [PW-1:0]     fs_waddr, link_waddr;
  logic [SLOT_W-1:0] fs_wdata;
  logic [LW-1:0]     link_wdata;
  logic [SA_W-1:0]   stk_raddr, stk_waddr;
  logic              stk_we;
  logic [SLOT_W-1:0] stk_wdata;

  // derived values
  logic [CLS_W-1:0]  dec_cls, cls;
  logic              dec_ok;
  logic [SLOT_W-1:0] capm1;
  logic [PW-1:0]     fpage, cur_pg;
  logic              fpage_ok;
  logic [OFF_W-1:0]  off;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] fs_new;
  logic [LW-1:0]     whole_new;
  logic [THR_W-1:0]  thr_eff, rel_cnt_new;
  logic              rel_whole;
  logic [ADDR_W-1:0] grant_addr;

  always_comb begin
    dec_cls = '0;
    dec_ok  = 1'b0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (size_q <= (SIZE_W'(32) << k)) begin
        dec_cls = CLS_W'(k);
        dec_ok  = 1'b1;
      end
    end
  end

  assign cls      = is_free_q ? fcls_q : dec_cls;
  assign capm1    = cap_m1(cls);
  assign fpage    = PW'(addr_q[ADDR_W-1:OFF_W]);
  assign fpage_ok = 32'(addr_q[ADDR_W-1:OFF_W]) < 32'(NUM_PAGES);
  assign off      = addr_q[OFF_W-1:0];
  assign rd_slot  = SLOT_W'(off >> (MIN_SHIFT + cls_rd_q));
  assign cur_pg   = cur_q[PW-1:0];
  assign fs_new   = fs_q + SLOT_W'(1);
  assign whole_new = whole_q[cls] + LW'(fs_new == capm1);
  assign thr_eff  = (thr_q == '0) ? THR_W'(1) : thr_q;
  assign rel_whole = (fs_rd_q == capm1);
  assign rel_cnt_new = cnt_q + THR_W'(rel_whole);
  assign grant_addr = ADDR_W'({cur_pg, {OFF_W{1'b0}}})
                    | ADDR_W'(OFF_W'(stk_rd_q) << (MIN_SHIFT + cls));

  // status to the controller
  always_comb begin
    stat_o           = '0;
    stat_o.bad_size  = (size_q == '0) || (32'(size_q) > 32'(MAX_REQ)) || !dec_ok;
    stat_o.cfo_zero  = (cfo_q[cls] == '0);
    stat_o.scan_hit  = !in_use_q[scan_q];
    stat_o.scan_last = (scan_q == LAST_PG);
    stat_o.fill_last = (fill_q == capm1 - SLOT_W'(1));
    stat_o.cur_null  = (cur_q == LINK_NULL);
    stat_o.walk_hit  = (fs_rd_q != '0);
    stat_o.walk_stop = (link_rd_q == LINK_NULL) || (steps_q == LAST_PG);
    stat_o.f_bad_pre = fpage_ok ? !in_use_q[fpage] : 1'b1;
    stat_o.f_bad_chk = (32'(cls_rd_q) >= 32'(NUM_CLASSES))
                    || ((off & obj_mask(cls_rd_q)) != '0)
                    || (rd_slot == '0)
                    || (fs_rd_q >= cap_m1(cls_rd_q));
    stat_o.dup_match = chk_v_q && (stk_rd_q == slot_q);
    stat_o.dup_done  = (dup_cnt_q == fs_q) && !chk_v_q;
    stat_o.over_thr  = 32'(whole_new) > 32'(thr_q);
    stat_o.rel_hit   = (rel_cnt_new == thr_eff);
    stat_o.rel_stop  = (link_rd_q == LINK_NULL) || (steps_q == LAST_PG);
  end

  // memory port selection
  always_comb begin
    if (cmd_in_i.walk_step || cmd_in_i.rel_step) pg_raddr = link_rd_q[PW-1:0];
    else if (cmd_in_i.frd)                        pg_raddr = fpage;
    else                                          pg_raddr = cur_pg;

    fs_we    = cmd_in_i.init_page || cmd_in_i.pop || cmd_in_i.commit;
    fs_waddr = cur_pg;
    fs_wdata = fs_rd_q - SLOT_W'(1);
    if (cmd_in_i.init_page) begin
      fs_waddr = scan_q;
      fs_wdata = capm1;
    end else if (cmd_in_i.commit) begin
      fs_waddr = fpage;
      fs_wdata = fs_new;
    end

    cls_we     = cmd_in_i.init_page;
    link_we    = cmd_in_i.init_page
              || (cmd_in_i.release_pg && (prev_q != LINK_NULL));
    link_waddr = cmd_in_i.init_page ? scan_q : prev_q[PW-1:0];
    link_wdata = cmd_in_i.init_page ? head_q[cls] : link_rd_q;

    stk_raddr = cmd_in_i.pop ? {cur_pg, fs_rd_q - SLOT_W'(1)} : {fpage, dup_cnt_q};
    stk_we    = cmd_in_i.fill_inc || cmd_in_i.commit;
    stk_waddr = cmd_in_i.commit ? {fpage, fs_q} : {scan_q, fill_q};
    stk_wdata = cmd_in_i.commit ? slot_q : fill_q + SLOT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (fs_we)   pg_fs_mem[fs_waddr]     <= fs_wdata;
    if (link_we) pg_link_mem[link_waddr] <= link_wdata;
    if (cls_we)  pg_cls_mem[scan_q]      <= cls;
    fs_rd_q   <= pg_fs_mem[pg_raddr];
    link_rd_q <= pg_link_mem[pg_raddr];
    cls_rd_q  <= pg_cls_mem[pg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_raddr];
  end

  // item and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load) begin
      size_q    <= request_size_i;
      addr_q    <= object_address_i;
      is_free_q <= (cmd_e'(cmd_i) == CMD_FREE);
      scan_q    <= '0;
    end
    if (cmd_in_i.scan_inc) scan_q <= scan_q + PW'(1);
    if (cmd_in_i.init_page) fill_q <= '0;
    if (cmd_in_i.fill_inc) fill_q <= fill_q + SLOT_W'(1);
    if (cmd_in_i.walk_start || cmd_in_i.rel_start) begin
      cur_q   <= head_q[cls];
      prev_q  <= LINK_NULL;
      steps_q <= '0;
      cnt_q   <= '0;
    end
    if (cmd_in_i.walk_step || cmd_in_i.rel_step) begin
      prev_q  <= cur_q;
      cur_q   <= link_rd_q;
      steps_q <= steps_q + PW'(1);
      cnt_q   <= rel_cnt_new;
    end
    if (cmd_in_i.f_latch) begin
      fcls_q    <= cls_rd_q;
      fs_q      <= fs_rd_q;
      slot_q    <= rd_slot;
      dup_cnt_q <= '0;
    end
    if (cmd_in_i.dup_step && (dup_cnt_q < fs_q)) dup_cnt_q <= dup_cnt_q + SLOT_W'(1);
  end

  // double free scan: read one stack entry a cycle, compare the next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_v_q <= 1'b0;
    end else begin
      chk_v_q <= cmd_in_i.dup_step && (dup_cnt_q < fs_q);
    end
  end

  // page and class bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      thr_q    <= THR_W'(THR_RESET);
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head_q[k]  <= LINK_NULL;
        cfo_q[k]   <= '0;
        whole_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      priority if (cmd_in_i.init_page) begin
        in_use_q[scan_q] <= 1'b1;
        head_q[cls]      <= LW'(scan_q);
        whole_q[cls]     <= whole_q[cls] + LW'(1);
        cfo_q[cls]       <= cfo_q[cls] + CFO_W'(capm1);
      end else if (cmd_in_i.pop) begin
        cfo_q[cls] <= cfo_q[cls] - CFO_W'(1);
        if (fs_rd_q == capm1) whole_q[cls] <= whole_q[cls] - LW'(1);
      end else if (cmd_in_i.commit) begin
        cfo_q[cls]   <= cfo_q[cls] + CFO_W'(1);
        whole_q[cls] <= whole_new;
      end else if (cmd_in_i.release_pg) begin
        in_use_q[cur_pg] <= 1'b0;
        cfo_q[cls]       <= cfo_q[cls] - CFO_W'(capm1);
        whole_q[cls]     <= whole_q[cls] - LW'(1);
        if (prev_q == LINK_NULL) head_q[cls] <= link_rd_q;
      end else begin
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.finish) begin
      status_o          <= cmd_in_i.status;
      granted_address_o <= cmd_in_i.grant ? grant_addr : '0;
      released_valid_o  <= cmd_in_i.release_pg;
      released_page_o   <= cmd_in_i.release_pg ? RPAGE_W'(cur_pg) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/size_class_slab_allocator.sv =====
// top level of the size-class slab allocator
// uses scsa_pkg, scsa_ctrl and scsa_dp
`default_nettype none

// Usage
// - an item (allocate or free) is taken on a rising edge with start high
//   and busy low; busy stays high until the result is out
// - the result sits on the result ports for exactly one cycle, marked by
//   done_o; the receiver cannot stall it, so it must take every transfer
// - reserve_threshold is written over the cfg channel (always ready),
//   only while busy is low and no result is pending
// - a bad size ends in the decode state, a free rejected on its page in
//   the page read state, and one rejected on its offset in the check state
// - an allocate from a class with free objects walks its page list, one
//   page a cycle over the page table port, then pops a slot and grants it
// - an allocate that takes a new page first scans page_in_use one page a
//   cycle (up to the page count), then writes the slot stack one slot a
//   cycle (up to 127 for the smallest class) before the walk
// - a free reads the page, compares each stacked slot once a cycle for
//   a double free (up to 126), commits, and when the class holds too many
//   wholly free pages walks the list one page a cycle to release one
// - one item at a time; the worst case is set by the slot stack
//   port (fill or double free scan) plus the page scan or list walk
// - after reset no page is in use, every class list is empty and the
//   threshold is 2; no clearing pass is needed
module size_class_slab_allocator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             cmd_i,
  input  wire logic [scsa_pkg::SIZE_W-1:0]      request_size_i,
  input  wire logic [scsa_pkg::ADDR_W-1:0]      object_address_i,
  output logic                                  done_o,
  output logic [scsa_pkg::ADDR_W-1:0]           granted_address_o,
  output logic [scsa_pkg::STATUS_W-1:0]         status_o,
  output logic                                  released_valid_o,
  output logic [scsa_pkg::RPAGE_W-1:0]          released_page_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [scsa_pkg::THR_W-1:0]       cfg_data_i
);
  import scsa_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // user issues threshold writes only while idle, unchecked; always ready
  assign cfg_ready_o = 1'b1;

  scsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (dp_stat),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (ctrl_cmd)
  );

  scsa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd_i),
    .request_size_i    (request_size_i),
    .object_address_i  (object_address_i),
    .cmd_in_i          (ctrl_cmd),
    .stat_o            (dp_stat),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .released_valid_o  (released_valid_o),
    .released_page_o   (released_page_o)
  );

endmodule

`default_nettype wire

// ===== sim/scsa_checker.sv =====
// result checker for the size-class slab allocator: predicts each result from the accepted
// commands and compares it with what the block returns; depends on scsa_pkg only
`default_nettype none

module scsa_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic                        cmd_i,
  input  wire logic [scsa_pkg::SIZE_W-1:0] request_size_i,
  input  wire logic [scsa_pkg::ADDR_W-1:0] object_address_i,
  input  wire logic                        done_o,
  input  wire logic [scsa_pkg::ADDR_W-1:0] granted_address_o,
  input  wire logic [1:0]                  status_o,
  input  wire logic                        released_valid_o,
  input  wire logic [5:0]                  released_page_o,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_o,
  input  wire logic [3:0]                  cfg_data_i,
  output int                               errors,
  output int                               outstanding
);
  import scsa_pkg::*;

  localparam int NP = NUM_PAGES_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           st;
    logic              rv;
    logic [5:0]        rp;
  } grant_t;

  grant_t      grants_due[$];
  logic [3:0]  thr;
  bit          in_use [NP];
  int          pg_cls [NP];
  int          pg_next [NP];
  int          pg_free [NP];
  int          stack [NP][SLOT_ROW];
  int          head [NUM_CLASSES];
  int          cls_free [NUM_CLASSES];
  int          cls_whole [NUM_CLASSES];

  function automatic grant_t mk(int a, status_e s, int rv, int rp);
    grant_t g;
    g.addr = ADDR_W'(a); g.st = s; g.rv = 1'(rv); g.rp = 6'(rp);
    return g;
  endfunction

  function automatic grant_t allocate(int size);
    int c, cap, p, n;
    if (size == 0 || size > MAX_REQ) return mk(0, ST_BAD_SIZE, 0, 0);
    for (c = 0; c < NUM_CLASSES; c++)
      if (size <= (32 << c)) break;
    if (c >= NUM_CLASSES) return mk(0, ST_BAD_SIZE, 0, 0);
    cap = PAGE_BYTES >> (5 + c);
    if (cls_free[c] == 0) begin
      for (p = 0; p < NP; p++)
        if (!in_use[p]) break;
      if (p >= NP) return mk(0, ST_NO_PAGE, 0, 0);
      in_use[p] = 1; pg_cls[p] = c; pg_next[p] = head[c]; head[c] = p;
      cls_whole[c]++;
      for (int i = 0; i + 1 < cap; i++) stack[p][i] = i + 1;
      pg_free[p] = cap - 1;
      cls_free[c] += cap - 1;
    end
    p = head[c];
    for (n = 0; p < NP && n < NP; n++) begin
      if (pg_free[p] != 0) break;
      p = pg_next[p];
    end
    if (p >= NP || n >= NP) return mk(0, ST_NO_PAGE, 0, 0);
    pg_free[p]--;
    cls_free[c]--;
    if (pg_free[p] == cap - 2) cls_whole[c]--;
    return mk(p * PAGE_BYTES + stack[p][pg_free[p]] * (32 << c), ST_OK, 0, 0);
  endfunction

  function automatic grant_t release_object(int a);
    int pg, off, c, cap, slot, limit, seen, cur, prev;
    pg = a / PAGE_BYTES; off = a % PAGE_BYTES;
    if (pg >= NP || !in_use[pg]) return mk(0, ST_BAD_FREE, 0, 0);
    c = pg_cls[pg];
    cap = PAGE_BYTES >> (5 + c);
    if ((off & ((32 << c) - 1)) != 0) return mk(0, ST_BAD_FREE, 0, 0);
    slot = off >> (5 + c);
    if (slot == 0 || pg_free[pg] >= cap - 1) return mk(0, ST_BAD_FREE, 0, 0);
    for (int i = 0; i < pg_free[pg]; i++)
      if (stack[pg][i] == slot) return mk(0, ST_BAD_FREE, 0, 0);
    stack[pg][pg_free[pg]] = slot;
    pg_free[pg]++;
    cls_free[c]++;
    if (pg_free[pg] == cap - 1) cls_whole[c]++;
    limit = (thr == 0) ? 1 : thr;
    if (cls_whole[c] > thr) begin
      seen = 0; prev = NP; cur = head[c];
      for (int n = 0; cur < NP && n < NP; n++) begin
        if (pg_free[cur] == cap - 1) seen++;
        if (seen == limit) begin
          if (prev >= NP) head[c] = pg_next[cur];
          else pg_next[prev] = pg_next[cur];
          cls_free[c] -= cap - 1;
          cls_whole[c]--;
          in_use[cur] = 0;
          return mk(0, ST_OK, 1, cur);
        end
        prev = cur;
        cur = pg_next[cur];
      end
    end
    return mk(0, ST_OK, 0, 0);
  endfunction

  assign outstanding = grants_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    if (!rst_ni) begin
      errors <= 0;
      thr = THR_W'(THR_RESET);
      grants_due.delete();
      for (int p = 0; p < NP; p++) in_use[p] = 0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] = NP; cls_free[c] = 0; cls_whole[c] = 0;
      end
    end else begin
      // result check first, then the new command of this edge
      if (done_o) begin
        if (grants_due.size() == 0) begin
          $display("%0t: result with nothing expected, got addr %0h st %0d rv %0d rp %0d",
                   $time, granted_address_o, status_o, released_valid_o, released_page_o);
          errors <= errors + 1;
        end else begin
          g = grants_due.pop_front();
          if (g != {granted_address_o, status_o, released_valid_o, released_page_o}) begin
            $display("%0t: expected addr %0h st %0d rv %0d rp %0d, got addr %0h st %0d rv %0d rp %0d",
                     $time, g.addr, g.st, g.rv, g.rp, granted_address_o, status_o,
                     released_valid_o, released_page_o);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) thr = cfg_data_i;
      if (start && !busy)
        grants_due.push_back(cmd_i == CMD_FREE ? release_object(object_address_i)
                                               : allocate(request_size_i));
    end
  end
endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench top for the size-class slab allocator: drives commands and threshold writes
// depends on scsa_pkg, size_class_slab_allocator and scsa_checker
`default_nettype none

module tb;
  import scsa_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic cmd_i = 0;
  logic [SIZE_W-1:0] request_size_i = 0;
  logic [ADDR_W-1:0] object_address_i = 0;
  logic cfg_valid_i = 0;
  logic [THR_W-1:0] cfg_data_i = 0;
  wire logic busy, done_o, released_valid_o, cfg_ready_o;
  wire logic [ADDR_W-1:0] granted_address_o;
  wire logic [1:0] status_o;
  wire logic [5:0] released_page_o;
  int errors, outstanding;
  int cycles = 0;

  // addresses handed out and not yet returned, used to build legal frees
  logic [ADDR_W-1:0] live_objects[$];

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  size_class_slab_allocator dut (.*);
  scsa_checker u_checker (.*);

  // keep the pool of live objects in step with granted results
  always @(posedge clk_i)
    if (done_o && status_o == ST_OK && !released_valid_o && granted_address_o != 0)
      live_objects.push_back(granted_address_o);

  // generous limit on the run, covering every item and the gaps between
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // one transfer: hold start until the block takes it
  task automatic issue(input cmd_e c, input int sz, input int a);
    cmd_i <= c;
    request_size_i <= SIZE_W'(sz);
    object_address_i <= ADDR_W'(a);
    start <= 1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 0;
    // wait for the block to finish before offering the next item
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic random_gap();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // threshold writes only once everything has drained
  task automatic set_threshold(input int v);
    while (outstanding != 0 || busy) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_data_i <= THR_W'(v);
    cfg_valid_i <= 1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic free_one(input bit legal);
    int k;
    if (legal && live_objects.size() > 0) begin
      k = $urandom_range(0, live_objects.size() - 1);
      issue(CMD_FREE, $urandom, live_objects[k]);
      live_objects.delete(k);
    end else begin
      issue(CMD_FREE, $urandom, $urandom);
    end
  endtask

  int thr_set[5] = '{1, 15, 0, 3, 2};

  initial begin
    int burst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: size edges, every class, bad frees, double free
    issue(CMD_ALLOC, 0, 0);
    issue(CMD_ALLOC, 2049, 0);
    issue(CMD_ALLOC, 16'hFFFF, 0);
    issue(CMD_ALLOC, 1, 0);
    issue(CMD_ALLOC, 2048, 0);
    for (int s = 32; s <= 1024; s = s * 2) issue(CMD_ALLOC, s + 1, 0);
    issue(CMD_FREE, 0, 18'h3FFFF);   // page 63, which is not in use
    issue(CMD_FREE, 0, 0);           // reserved slot of page 0
    issue(CMD_FREE, 0, 1);           // misaligned offset
    while (outstanding != 0) @(posedge clk_i);
    free_one(1);
    issue(CMD_FREE, 0, object_address_i);  // double free of the same object
    issue(CMD_FREE, 0, 18'h3F000);

    // random phases, each with its own threshold
    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(thr_set[ph]);
      for (int n = 0; n < 266; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 266; b++, n++) begin
          case ($urandom_range(0, 9))
            0: issue(CMD_ALLOC, $urandom, $urandom);
            1, 2, 3, 4: issue(CMD_ALLOC,
                            $urandom_range(1, 1 << $urandom_range(5, 11)), $urandom);
            5: free_one(0);
            default: free_one(1);
          endcase
        end
        random_gap();
      end
      // in phase 2, drain fully, which frees pages back for release tests
      if (ph == 2)
        while (live_objects.size() > 0) free_one(1);
    end

    while (outstanding != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/scsa_pkg.sv
hdl/scsa_ctrl.sv
hdl/scsa_dp.sv
hdl/size_class_slab_allocator.sv
sim/scsa_checker.sv
sim/tb.sv
